### rtl/core/cim_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cim_pkg
// shared sizes, codes, transaction types and row pick helper for the crossbar
// ----------------------------------------------------------------------------
package cim_pkg;

    localparam int ROWS        = 8;
    localparam int COLS        = 8;
    localparam int CELL_LEVELS = 4;

    localparam int LANE_MAX = 8;
    localparam int SEL_MAX  = 8;
    localparam int LANES    = (COLS < LANE_MAX) ? COLS : LANE_MAX;
    localparam int SEL_ROWS = (ROWS < SEL_MAX) ? ROWS : SEL_MAX;

    localparam int CELL_W  = 2;
    localparam int DRV_W   = 4;
    localparam int VAL_W   = 9;
    localparam int ROW_W   = $clog2(ROWS);
    localparam int SEL_W   = $clog2(SEL_ROWS);
    localparam int LANE_CW = (LANES > 1) ? $clog2(LANES) : 1;

    localparam logic [CELL_W-1:0] CELL_TOP =
        CELL_W'((CELL_LEVELS - 1 > 3) ? 3 : CELL_LEVELS - 1);
    localparam logic [VAL_W-1:0] VAL_TOP = '1;

    localparam logic [2:0] K_WR  = 3'd0;
    localparam logic [2:0] K_RD  = 3'd1;
    localparam logic [2:0] K_VMM = 3'd2;
    localparam logic [2:0] K_AND = 3'd3;
    localparam logic [2:0] K_OR  = 3'd4;
    localparam logic [2:0] K_XOR = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_ROW   = 2'd1;
    localparam logic [1:0] ST_FEW_ROWS = 2'd2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  row_select;
        logic [7:0]  column_mask;
        logic [15:0] write_data;
        logic [31:0] row_drive;
    } t_cmd;

    typedef struct packed {
        logic [2:0] lane;
        logic [8:0] value;
        logic [1:0] status;
        logic       last;
    } t_result;

    typedef logic [LANES-1:0][CELL_W-1:0] t_row;
    typedef logic [LANES-1:0][VAL_W-1:0]  t_acc;

    typedef struct packed {
        logic [2:0]       kind;
        logic             first;
        logic             contrib;
        logic [DRV_W-1:0] drive;
    } t_alu_ctl;

    typedef struct packed {
        logic             found;
        logic [ROW_W-1:0] idx;
    } t_pick;

    function automatic t_pick first_row(input logic [SEL_ROWS-1:0] sel);
        t_pick pick;
        pick = '0;
        for (int r = SEL_ROWS - 1; r >= 0; r--) begin
            if (sel[r]) begin
                pick.found = 1'b1;
                pick.idx   = ROW_W'(r);
            end
        end
        return pick;
    endfunction

endpackage
`default_nettype wire

### rtl/core/cim_cell_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cim_cell_mem
// cell storage, one row per entry, per-lane write enables, registered read
// ----------------------------------------------------------------------------
module cim_cell_mem
    import cim_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [ROW_W-1:0] i_wr_addr,
    input  wire logic [LANES-1:0] i_wr_mask,
    input  wire t_row             i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [ROW_W-1:0] i_rd_addr,
    output t_row                  o_rd_data
);

    t_row mem [ROWS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            for (int k = 0; k < LANES; k++) begin
                if (i_wr_mask[k]) begin
                    mem[i_wr_addr][k] <= i_wr_data[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

### rtl/core/cim_lane_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cim_lane_alu
// per-lane update of the accumulators from one row read back from memory
// ----------------------------------------------------------------------------
module cim_lane_alu
    import cim_pkg::*;
(
    input  wire t_alu_ctl i_ctl,
    input  wire t_acc     i_acc,
    input  wire t_row     i_row,
    output t_acc          o_acc
);

    always_comb begin
        logic [VAL_W-1:0]  cell_val;
        logic [5:0]        prod;
        logic [VAL_W:0]    sum;
        o_acc = i_acc;
        for (int k = 0; k < LANES; k++) begin
            cell_val = VAL_W'(i_row[k]);
            prod = 6'(i_row[k]) * 6'(i_ctl.drive);
            sum  = (VAL_W + 1)'(i_acc[k]) + (VAL_W + 1)'(prod);
            if (i_ctl.kind == K_VMM) begin
                if (i_ctl.contrib) begin
                    o_acc[k] = sum[VAL_W] ? VAL_TOP : sum[VAL_W-1:0];
                end
            end else if (i_ctl.first || i_ctl.kind == K_RD) begin
                o_acc[k] = cell_val;
            end else begin
                unique case (i_ctl.kind)
                    K_AND:   o_acc[k] = VAL_W'(i_acc[k][CELL_W-1:0] * cell_val[CELL_W-1:0]);
                    K_OR:    o_acc[k] = i_acc[k] | cell_val;
                    K_XOR:   o_acc[k] = i_acc[k] ^ cell_val;
                    default: o_acc[k] = i_acc[k];
                endcase
            end
        end
    end

endmodule
`default_nettype wire

### rtl/core/cim_crossbar_array.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cim_crossbar_array
// crossbar command sequencer around a row-wide cell memory
// ----------------------------------------------------------------------------
// latency to the last result: a write or an error result comes the cycle after
// acceptance; read, logic and multiply pass S_READ, S_WAIT and then S_EMIT
// throughput: one transaction at a time, set by one memory row read a cycle
// and one lane result a cycle; busy clears after the last result, so the next
// transaction is taken in the following cycle at the earliest
// reset: sequencer returns to idle, cell contents stay undefined until written
// results come out one a cycle and the receiver cannot stall them
module cim_crossbar_array
    import cim_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_cmd i_cmd,
    output logic      busy,
    output logic      o_strobe,
    output t_result   o_result
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_WAIT   = 3'd2;
    localparam logic [2:0] S_EMIT   = 3'd3;
    localparam logic [2:0] S_SINGLE = 3'd4;

    logic [2:0]                    r_state, n_state;
    logic [2:0]                    r_kind;
    logic [SEL_ROWS-1:0]           r_sel;
    logic [SEL_ROWS-1:0][DRV_W-1:0] r_drive;
    logic [ROW_W-1:0]              r_r1, r_r2;
    logic [SEL_W-1:0]              r_step, r_last_step;
    logic                          r_rd_valid;
    logic [SEL_W-1:0]              r_rd_step;
    logic [LANE_CW-1:0]            r_lane;
    logic [1:0]                    r_status;
    t_acc                          r_acc;

    logic              accept;
    t_pick             pick1, pick2;
    logic              wr_en;
    t_row              wr_data;
    logic              rd_en;
    logic [ROW_W-1:0]  rd_addr;
    t_row              rd_data;
    t_alu_ctl          alu_ctl;
    t_acc              alu_acc;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign pick1  = first_row(i_cmd.row_select[SEL_ROWS-1:0]);
    assign pick2  = first_row(i_cmd.row_select[SEL_ROWS-1:0]
                              & (i_cmd.row_select[SEL_ROWS-1:0] - SEL_ROWS'(1)));

    assign wr_en = accept && (i_cmd.kind == K_WR) && pick1.found;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            wr_data[k] = (i_cmd.write_data[2*k +: CELL_W] > CELL_TOP)
                         ? CELL_TOP : i_cmd.write_data[2*k +: CELL_W];
        end
    end

    assign rd_en = (r_state == S_READ);

    always_comb begin
        if (r_kind == K_VMM) begin
            rd_addr = ROW_W'(r_step);
        end else if (r_step == '0) begin
            rd_addr = r_r1;
        end else begin
            rd_addr = r_r2;
        end
    end

    cim_cell_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (pick1.idx),
        .i_wr_mask (i_cmd.column_mask[LANES-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign alu_ctl.kind    = r_kind;
    assign alu_ctl.first   = (r_rd_step == '0);
    assign alu_ctl.contrib = r_sel[r_rd_step] && (r_drive[r_rd_step] != '0);
    assign alu_ctl.drive   = r_drive[r_rd_step];

    cim_lane_alu u_alu (
        .i_ctl (alu_ctl),
        .i_acc (r_acc),
        .i_row (rd_data),
        .o_acc (alu_acc)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_cmd.kind)
                        K_WR:                n_state = S_SINGLE;
                        K_RD:                n_state = pick1.found ? S_READ : S_SINGLE;
                        K_VMM:               n_state = S_READ;
                        K_AND, K_OR, K_XOR:  n_state = pick2.found ? S_READ : S_SINGLE;
                        default:             n_state = S_IDLE;
                    endcase
                end
            end
            S_READ: begin
                if (r_step == r_last_step) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT:   n_state = S_EMIT;
            S_EMIT: begin
                if (r_lane == LANE_CW'(LANES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_SINGLE: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rd_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= i_cmd.kind;
            r_sel   <= i_cmd.row_select[SEL_ROWS-1:0];
            r_drive <= i_cmd.row_drive[SEL_ROWS*DRV_W-1:0];
            r_r1    <= pick1.idx;
            r_r2    <= pick2.idx;
            r_step  <= '0;
            r_acc   <= '0;
            unique case (i_cmd.kind)
                K_WR:    r_status <= pick1.found ? ST_OK : ST_NO_ROW;
                K_RD:    r_status <= ST_NO_ROW;
                default: r_status <= ST_FEW_ROWS;
            endcase
            unique case (i_cmd.kind)
                K_VMM:   r_last_step <= SEL_W'(SEL_ROWS - 1);
                K_RD:    r_last_step <= '0;
                default: r_last_step <= SEL_W'(1);
            endcase
        end else begin
            if (rd_en) begin
                r_step <= r_step + SEL_W'(1);
            end
            if (r_rd_valid) begin
                r_acc <= alu_acc;
            end
        end
        if (rd_en) begin
            r_rd_step <= r_step;
        end
        if (r_state == S_EMIT) begin
            r_lane <= r_lane + LANE_CW'(1);
        end else begin
            r_lane <= '0;
        end
    end

    always_comb begin
        o_strobe = 1'b0;
        o_result = '0;
        if (r_state == S_EMIT) begin
            o_strobe        = 1'b1;
            o_result.lane   = 3'(r_lane);
            o_result.value  = r_acc[r_lane];
            o_result.status = ST_OK;
            o_result.last   = (r_lane == LANE_CW'(LANES - 1));
        end else if (r_state == S_SINGLE) begin
            o_strobe        = 1'b1;
            o_result.status = r_status;
            o_result.last   = 1'b1;
        end
    end

endmodule
`default_nettype wire

### rtl/core/cim_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cim_checker
// port-level checks on the crossbar transaction sequencing
// ----------------------------------------------------------------------------
module cim_checker
    import cim_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    start,
    input wire t_cmd    i_cmd,
    input wire logic    busy,
    input wire logic    o_strobe,
    input wire t_result o_result
);

    // results only come out while a transaction is in progress
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe outside a transaction");

    // a command with a defined kind keeps the block busy afterwards
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd.kind == K_WR || i_cmd.kind == K_RD
            || i_cmd.kind == K_VMM || i_cmd.kind == K_AND
            || i_cmd.kind == K_OR || i_cmd.kind == K_XOR)) |=> busy)
        else $error("accepted command did not start a transaction");

    // the final result ends the transaction
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |=> (!busy && !o_strobe))
        else $error("activity after final result");

    // lane results follow each other with rising lane index
    a_lane_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |=>
            (o_strobe && o_result.lane == $past(o_result.lane) + 3'd1))
        else $error("lane results not contiguous");

    // an error status is a single empty result
    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status != ST_OK) |->
            (o_result.last && o_result.value == '0 && o_result.lane == '0))
        else $error("malformed error result");

endmodule

bind cim_crossbar_array cim_checker u_cim_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_cmd    (i_cmd),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
`default_nettype wire

### dv/cim_crossbar_array_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cim_crossbar_array_tb
// self-checking bench for the crossbar: seeds every row, runs directed
// commands, then random command streams with idle bursts and drain pauses;
// a scoreboard predicts each lane result and compares it on the strobe
// ----------------------------------------------------------------------------
module cim_crossbar_array_tb;
    import cim_pkg::*;

    localparam logic [2:0] K_SPARE6 = 3'd6;
    localparam logic [2:0] K_SPARE7 = 3'd7;
    localparam int REPORT_MAX  = 10;
    localparam int STALL_LIMIT = 1000;
    localparam int TAIL_CYCLES = 40;

    class crossbar_scoreboard;
        logic [CELL_W-1:0] cells [ROWS][COLS];
        t_result lane_q[$];
        int failures;

        function new();
            failures = 0;
            foreach (cells[r, c]) cells[r][c] = '0;
        endfunction

        function int lowest_sel(logic [7:0] sel, int from);
            for (int r = from; r < SEL_ROWS; r++) begin
                if (sel[r]) return r;
            end
            return -1;
        endfunction

        function void push_single(logic [1:0] st);
            t_result res;
            res.lane   = '0;
            res.value  = '0;
            res.status = st;
            res.last   = 1'b1;
            lane_q.push_back(res);
        endfunction

        function void push_lanes(input int vals [LANES]);
            t_result res;
            for (int k = 0; k < LANES; k++) begin
                res.lane   = 3'(k);
                res.value  = (vals[k] > int'(VAL_TOP)) ? VAL_TOP : 9'(vals[k]);
                res.status = ST_OK;
                res.last   = (k == LANES - 1);
                lane_q.push_back(res);
            end
        endfunction

        // accepted command transaction: update the cell copy and queue its expected results
        function void note_cmd(t_cmd c);
            int vals [LANES];
            int r1;
            int r2;
            int a;
            int b;
            logic [CELL_W-1:0] lv;
            logic [DRV_W-1:0] d;
            foreach (vals[k]) vals[k] = 0;
            case (c.kind)
                K_WR: begin
                    r1 = lowest_sel(c.row_select, 0);
                    if (r1 < 0) begin
                        push_single(ST_NO_ROW);
                    end else begin
                        for (int k = 0; k < LANES; k++) begin
                            if (c.column_mask[k]) begin
                                lv = c.write_data[2*k +: 2];
                                if (lv > CELL_TOP) lv = CELL_TOP;
                                cells[r1][COLS-1-k] = lv;
                            end
                        end
                        push_single(ST_OK);
                    end
                end
                K_RD: begin
                    r1 = lowest_sel(c.row_select, 0);
                    if (r1 < 0) begin
                        push_single(ST_NO_ROW);
                    end else begin
                        for (int k = 0; k < LANES; k++) vals[k] = int'(cells[r1][COLS-1-k]);
                        push_lanes(vals);
                    end
                end
                K_VMM: begin
                    for (int r = 0; r < SEL_ROWS; r++) begin
                        d = c.row_drive[4*r +: 4];
                        if (c.row_select[r] && d != '0) begin
                            for (int k = 0; k < LANES; k++)
                                vals[k] += int'(cells[r][COLS-1-k]) * int'(d);
                        end
                    end
                    push_lanes(vals);
                end
                K_AND, K_OR, K_XOR: begin
                    r1 = lowest_sel(c.row_select, 0);
                    r2 = (r1 < 0) ? -1 : lowest_sel(c.row_select, r1 + 1);
                    if (r2 < 0) begin
                        push_single(ST_FEW_ROWS);
                    end else begin
                        for (int k = 0; k < LANES; k++) begin
                            a = int'(cells[r1][COLS-1-k]);
                            b = int'(cells[r2][COLS-1-k]);
                            if (c.kind == K_AND) vals[k] = a * b;
                            else if (c.kind == K_OR) vals[k] = a | b;
                            else vals[k] = a ^ b;
                        end
                        push_lanes(vals);
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void check(t_result got);
            t_result want;
            if (lane_q.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("%0t unexpected result: lane %0d value %0d status %0d last %0b",
                             $time, got.lane, got.value, got.status, got.last);
                return;
            end
            want = lane_q.pop_front();
            if (got.lane !== want.lane || got.value !== want.value ||
                got.status !== want.status || got.last !== want.last) begin
                failures++;
                if (failures <= REPORT_MAX) begin
                    $display("%0t mismatch: expected lane %0d value %0d status %0d last %0b",
                             $time, want.lane, want.value, want.status, want.last);
                    $display("%0t           actual lane %0d value %0d status %0d last %0b",
                             $time, got.lane, got.value, got.status, got.last);
                end
            end
        endfunction

        function int pending();
            return lane_q.size();
        endfunction
    endclass

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_cmd    i_cmd   = '0;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    crossbar_scoreboard sb;
    int cmds_taken   = 0;
    int stall_cycles = 0;

    always #2 i_clk = ~i_clk;

    cim_crossbar_array u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) sb.check(o_result);
            if (start && !busy) begin
                sb.note_cmd(i_cmd);
                cmds_taken++;
            end
            if (o_strobe || (start && !busy)) stall_cycles = 0;
            else stall_cycles++;
        end
    end

    function automatic t_cmd mk_cmd(logic [2:0] kind, logic [7:0] sel, logic [7:0] mask,
                                    logic [15:0] wdata, logic [31:0] drive);
        t_cmd c;
        c.kind        = kind;
        c.row_select  = sel;
        c.column_mask = mask;
        c.write_data  = wdata;
        c.row_drive   = drive;
        return c;
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) c.kind = K_WR;
        else if (pick < 30) c.kind = K_RD;
        else if (pick < 55) c.kind = K_VMM;
        else if (pick < 68) c.kind = K_AND;
        else if (pick < 80) c.kind = K_OR;
        else if (pick < 93) c.kind = K_XOR;
        else if (pick < 97) c.kind = K_SPARE6;
        else c.kind = K_SPARE7;
        pick = $urandom_range(0, 9);
        if (pick == 0) c.row_select = '0;
        else if (pick < 4) c.row_select = 8'd1 << $urandom_range(0, 7);
        else if (pick < 6)
            c.row_select = (8'd1 << $urandom_range(0, 7)) | (8'd1 << $urandom_range(0, 7));
        else c.row_select = 8'($urandom);
        pick = $urandom_range(0, 9);
        if (pick == 0) c.column_mask = '0;
        else if (pick == 1) c.column_mask = '1;
        else c.column_mask = 8'($urandom);
        c.write_data = 16'($urandom);
        c.row_drive  = $urandom;
        if ($urandom_range(0, 2) == 0) c.row_drive &= $urandom;
        return c;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_cmd(input t_cmd c);
        int seen;
        seen = cmds_taken;
        start <= 1'b1;
        i_cmd <= c;
        do @(negedge i_clk); while (cmds_taken == seen);
    endtask

    task automatic idle_for(input int n);
        start <= 1'b0;
        i_cmd <= random_cmd();
        repeat (n) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic run_random(input int count, input bit with_gaps);
        int done;
        t_cmd c;
        done = 0;
        while (done < count) begin
            c = random_cmd();
            if (c.kind != K_SPARE6 && c.kind != K_SPARE7) done++;
            send_cmd(c);
            if (with_gaps && $urandom_range(0, 2) == 0) idle_for($urandom_range(1, 12));
        end
    endtask

    initial begin
        logic [15:0] row_pat [4];
        row_pat[0] = 16'h0000;
        row_pat[1] = 16'hFFFF;
        row_pat[2] = 16'hAAAA;
        row_pat[3] = 16'h5555;
        sb = new();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // every row written in full before anything reads the array
        for (int r = 0; r < 8; r++)
            send_cmd(mk_cmd(K_WR, 8'hFF << r, 8'hFF,
                            (r < 4) ? row_pat[r] : 16'($urandom), $urandom));
        send_cmd(mk_cmd(K_WR, 8'h00, 8'hFF, 16'hFFFF, 32'h0));
        send_cmd(mk_cmd(K_WR, 8'h04, 8'h00, 16'hFFFF, 32'h0));
        send_cmd(mk_cmd(K_WR, 8'h80, 8'h81, 16'hFFFF, 32'hFFFF_FFFF));
        send_cmd(mk_cmd(K_RD, 8'hFF, 8'h00, 16'h0, 32'h0));
        send_cmd(mk_cmd(K_RD, 8'h80, 8'hFF, 16'h0, 32'h0));
        send_cmd(mk_cmd(K_RD, 8'h00, 8'h00, 16'h0, 32'h0));
        send_cmd(mk_cmd(K_VMM, 8'hFF, 8'h00, 16'h0, 32'hFFFF_FFFF));
        send_cmd(mk_cmd(K_VMM, 8'h00, 8'h00, 16'h0, 32'hFFFF_FFFF));
        send_cmd(mk_cmd(K_VMM, 8'hFF, 8'h00, 16'h0, 32'h0));
        send_cmd(mk_cmd(K_VMM, 8'hA5, 8'h00, 16'h0, 32'hF0F0_1234));
        send_cmd(mk_cmd(K_AND, 8'h0A, 8'h00, 16'h0, 32'h0));
        send_cmd(mk_cmd(K_OR, 8'hC0, 8'h00, 16'h0, 32'h0));
        send_cmd(mk_cmd(K_XOR, 8'h06, 8'h00, 16'h0, 32'h0));
        send_cmd(mk_cmd(K_AND, 8'h10, 8'h00, 16'h0, 32'h0));
        send_cmd(mk_cmd(K_OR, 8'h00, 8'h00, 16'h0, 32'h0));
        send_cmd(mk_cmd(K_XOR, 8'h80, 8'h00, 16'h0, 32'h0));
        send_cmd(mk_cmd(K_SPARE6, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF));
        send_cmd(mk_cmd(K_SPARE7, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF));
        wait_drained();

        run_random(210, 1'b1);
        wait_drained();
        run_random(160, 1'b1);
        wait_drained();
        run_random(60, 1'b0);

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        do @(negedge i_clk); while (stall_cycles < STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
